// ===== sv/lpm_pkg.sv =====
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants of the route table
// Beat formats, stored route entry, status codes, controller command and
// status groups, and the prefix length helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpm_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic [1:0] ST_ADDED   = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_FOUND   = 2'd2;
	localparam logic [1:0] ST_NOROUTE = 2'd3;

	typedef struct packed {
		logic        action;
		logic [31:0] lookup_address;
		logic [31:0] new_dest;
		logic [31:0] new_mask;
		logic [31:0] new_gateway;
		logic [3:0]  new_iface;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] hit_gateway;
		logic [3:0]  hit_iface;
		logic [31:0] hit_dest;
		logic [31:0] hit_mask;
	} out_beat_t;

	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [3:0]  iface;
	} lpm_entry_t;

	typedef struct packed {
		logic load_req;
		logic exec;
		logic scan;
		logic load_out;
	} lpm_cmd_t;

	typedef struct packed {
		logic is_add;
		logic empty;
		logic last;
	} lpm_sts_t;

	// leading ones of a mask, counted from bit 31
	function automatic logic [5:0] prefix_len(input logic [31:0] m);
		logic [5:0] len;
		len = 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (!m[i]) begin
				len = 6'(31 - i);
			end
		end
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== sv/lpm_ram.sv =====
// ----------------------------------------------------------------------------
// lpm_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/lpm_datapath.sv =====
// ----------------------------------------------------------------------------
// lpm_datapath: route storage, scan and best-match tracking
// Holds the request, the route count, the entry RAM, the scan pointer, the
// best match so far and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpm_datapath #(
	parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lpm_pkg::in_beat_t in_data,
	input  wire lpm_pkg::lpm_cmd_t cmd,
	output lpm_pkg::lpm_sts_t      sts,
	output lpm_pkg::out_beat_t     out_data
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ENT_W = $bits(lpm_pkg::lpm_entry_t);

	lpm_pkg::in_beat_t   req_q;
	lpm_pkg::out_beat_t  out_q;
	lpm_pkg::out_beat_t  out_d;
	lpm_pkg::lpm_entry_t wr_ent;
	lpm_pkg::lpm_entry_t rd_ent;
	lpm_pkg::lpm_entry_t best_q;
	logic [ENT_W-1:0]    rd_raw;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    idx_q;
	logic                vld_s1;
	logic                found_q;
	logic [5:0]          best_len_q;
	logic [5:0]          cur_len;
	logic [1:0]          add_st_q;
	logic                full;
	logic                wr_en;
	logic                hit;
	logic                take;

	assign full  = (count_q == CNT_W'(TABLE_DEPTH));
	assign wr_en = cmd.exec && (req_q.action == lpm_pkg::ACT_ADD) && !full;

	assign wr_ent.dest    = req_q.new_dest;
	assign wr_ent.mask    = req_q.new_mask;
	assign wr_ent.gateway = req_q.new_gateway;
	assign wr_ent.iface   = req_q.new_iface;

	lpm_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_ent),
		.rd_en   (cmd.scan),
		.rd_addr (idx_q),
		.rd_data (rd_raw)
	);

	assign rd_ent  = lpm_pkg::lpm_entry_t'(rd_raw);
	assign cur_len = lpm_pkg::prefix_len(rd_ent.mask);
	assign hit     = ((rd_ent.dest ^ req_q.lookup_address) & rd_ent.mask) == 32'd0;
	assign take    = vld_s1 && hit && (!found_q || (cur_len > best_len_q));

	assign sts.is_add = (req_q.action == lpm_pkg::ACT_ADD);
	assign sts.empty  = (count_q == '0);
	assign sts.last   = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	always_comb begin
		out_d = '0;
		if (req_q.action == lpm_pkg::ACT_ADD) begin
			out_d.status = add_st_q;
		end else if (found_q) begin
			out_d.status      = lpm_pkg::ST_FOUND;
			out_d.hit_gateway = best_q.gateway;
			out_d.hit_iface   = best_q.iface;
			out_d.hit_dest    = best_q.dest;
			out_d.hit_mask    = best_q.mask;
		end else begin
			out_d.status = lpm_pkg::ST_NOROUTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan;
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.exec) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= in_data;
		end
		if (cmd.exec) begin
			add_st_q <= full ? lpm_pkg::ST_FULL : lpm_pkg::ST_ADDED;
		end
		if (take) begin
			best_q     <= rd_ent;
			best_len_q <= cur_len;
		end
		if (cmd.load_out) begin
			out_q <= out_d;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

// ===== sv/lpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpm_ctrl: request sequencer
// Walks each beat through execute, then, for a lookup on a non-empty table,
// through table scan and drain, and parks the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire lpm_pkg::lpm_sts_t sts,
	output lpm_pkg::lpm_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.load_req = in_valid && in_ready;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.is_add || sts.empty) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EXEC))
		else $error("accepted beat did not enter execute");

	a_scan_not_add: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (!sts.is_add && !sts.empty))
		else $error("scan issued for add or empty table");

	a_drain_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> $past(state_q == S_SCAN))
		else $error("drain entered without scan");

	a_load_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending beat");

endmodule

`default_nettype wire

// ===== sv/longest_prefix_match_route_table_core.sv =====
// ----------------------------------------------------------------------------
// longest_prefix_match_route_table_core: IPv4 longest prefix match table
// Each input beat either appends a route or looks up an address; each beat
// yields exactly one result beat.
//
// Channels: in_valid/in_ready/in_data and out_valid/out_ready/out_data,
// valid-ready, a beat moves when valid and ready are both high.
// One beat is in work at a time; in_ready is high while the sequencer idles.
// Add: the route is written in execute unless the table is full, and the
// result is registered in done; the next beat is taken once back in idle.
// Lookup: the entry RAM is read one route per cycle in scan, then drain lets
// the last read reach the best match before the result is registered in
// done; with an empty table, execute goes straight to done.
// A finished result waits in the output register while the next beat is
// accepted; a further result waits until out_ready takes the pending one.
// Reset empties the table (route count to zero) and clears out_valid.
// Entry storage needs no clearing pass: only entries below the count are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module longest_prefix_match_route_table_core #(
	parameter int TABLE_DEPTH = lpm_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire lpm_pkg::in_beat_t in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output lpm_pkg::out_beat_t     out_data
);

	lpm_pkg::lpm_cmd_t cmd;
	lpm_pkg::lpm_sts_t sts;

	lpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lpm_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

// ===== tb/lpm_route_checker.sv =====
// ----------------------------------------------------------------------------
// lpm_route_checker: result checker for the longest prefix match route table
// Watches both channels, keeps a shadow route table, predicts the answer to
// every accepted beat and compares each result beat, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpm_route_checker #(
	parameter int DEPTH = lpm_pkg::TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  lpm_pkg::in_beat_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  lpm_pkg::out_beat_t out_data,
	output int                 fail_count,
	output int                 answers_due
);

	localparam int RING = 8;

	lpm_pkg::lpm_entry_t routes [DEPTH];
	int                  route_total;
	lpm_pkg::out_beat_t  answer_ring [RING];
	int                  ring_head;
	int                  ring_tail;

	initial begin
		fail_count  = 0;
		answers_due = 0;
		route_total = 0;
		ring_head   = 0;
		ring_tail   = 0;
	end

	function automatic int lead_ones(input logic [31:0] m);
		int n;
		n = 0;
		while (n < 32 && m[31 - n]) n++;
		return n;
	endfunction

	// update the shadow table and work out the answer to one beat
	function automatic lpm_pkg::out_beat_t apply_beat(input lpm_pkg::in_beat_t b);
		lpm_pkg::out_beat_t r;
		int                 best;
		int                 best_len;
		int                 len;
		r = '0;
		if (b.action == lpm_pkg::ACT_ADD) begin
			if (route_total >= DEPTH) begin
				r.status = lpm_pkg::ST_FULL;
			end else begin
				routes[route_total].dest    = b.new_dest;
				routes[route_total].mask    = b.new_mask;
				routes[route_total].gateway = b.new_gateway;
				routes[route_total].iface   = b.new_iface;
				route_total++;
				r.status = lpm_pkg::ST_ADDED;
			end
			return r;
		end
		best     = -1;
		best_len = -1;
		for (int i = 0; i < route_total; i++) begin
			if (((routes[i].dest ^ b.lookup_address) & routes[i].mask) == 32'h0) begin
				len = lead_ones(routes[i].mask);
				if (len > best_len) begin
					best     = i;
					best_len = len;
				end
			end
		end
		if (best < 0) begin
			r.status = lpm_pkg::ST_NOROUTE;
		end else begin
			r.status      = lpm_pkg::ST_FOUND;
			r.hit_gateway = routes[best].gateway;
			r.hit_iface   = routes[best].iface;
			r.hit_dest    = routes[best].dest;
			r.hit_mask    = routes[best].mask;
		end
		return r;
	endfunction

	task automatic compare_beat(input lpm_pkg::out_beat_t got,
			input lpm_pkg::out_beat_t want);
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			fail_count++;
		end
		if (got.hit_gateway !== want.hit_gateway) begin
			$error("hit_gateway: expected %h, got %h", want.hit_gateway, got.hit_gateway);
			fail_count++;
		end
		if (got.hit_iface !== want.hit_iface) begin
			$error("hit_iface: expected %0d, got %0d", want.hit_iface, got.hit_iface);
			fail_count++;
		end
		if (got.hit_dest !== want.hit_dest) begin
			$error("hit_dest: expected %h, got %h", want.hit_dest, got.hit_dest);
			fail_count++;
		end
		if (got.hit_mask !== want.hit_mask) begin
			$error("hit_mask: expected %h, got %h", want.hit_mask, got.hit_mask);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lpm_pkg::out_beat_t want;
		if (!arst_n) begin
			ring_head   = 0;
			ring_tail   = 0;
			route_total = 0;
			answers_due = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (ring_tail == ring_head) begin
					$error("result beat with nothing expected: status %0d", out_data.status);
					fail_count++;
				end else begin
					want = answer_ring[ring_head % RING];
					ring_head++;
					compare_beat(out_data, want);
				end
			end
			if (in_valid && in_ready) begin
				if (ring_tail - ring_head >= RING) begin
					$error("too many beats in flight: %0d", ring_tail - ring_head);
					fail_count++;
				end else begin
					answer_ring[ring_tail % RING] = apply_beat(in_data);
					ring_tail++;
				end
			end
			answers_due = ring_tail - ring_head;
		end
	end

endmodule

// ===== tb/longest_prefix_match_route_table_core_tb.sv =====
// ----------------------------------------------------------------------------
// longest_prefix_match_route_table_core_tb: top of the route table testbench
// Drives a directed set of adds and lookups (empty table, default route,
// host routes, ties, non-contiguous masks), then random traffic built around
// a few nested prefixes until the table fills up and overflows. The sender
// works in bursts and the receiver stalls on its own pattern, with one long
// hold-off; a separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module longest_prefix_match_route_table_core_tb;

	localparam int DEPTH        = lpm_pkg::TABLE_DEPTH_DEF;
	localparam int QUIET_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 300;
	localparam int RANDOM_BEATS = 880;
	localparam int KNOWN_MAX    = 1024;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	lpm_pkg::in_beat_t  in_data;
	logic               out_valid;
	logic               out_ready;
	lpm_pkg::out_beat_t out_data;

	int fail_count;
	int answers_due;
	int results_taken;
	int quiet_cycles;
	int burst_left;
	int known_total;

	logic [31:0] net_base [4];
	logic [31:0] known_dest [KNOWN_MAX];
	logic [31:0] known_mask [KNOWN_MAX];

	longest_prefix_match_route_table_core #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	lpm_route_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.answers_due(answers_due)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (out_valid && out_ready) begin
			results_taken <= results_taken + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[longest_prefix_match_route_table_core] ERROR");
			$finish;
		end
	end

	// receiver: ready pattern changes at random intervals, one long hold
	initial begin
		int mode;
		int span;
		bit held;
		out_ready = 1'b0;
		held      = 1'b0;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 120);
			repeat (span) begin
				@(negedge clk);
				if (!held && results_taken >= HOLD_AFTER) begin
					held = 1'b1;
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES - 1) @(negedge clk);
				end else begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= ($urandom_range(0, 1) == 0);
						2: out_ready <= ($urandom_range(0, 3) == 0);
						default: out_ready <= ($urandom_range(0, 7) != 0);
					endcase
				end
			end
		end
	end

	task automatic offer(input lpm_pkg::in_beat_t b);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 12)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic add_route(input logic [31:0] dst, input logic [31:0] msk,
			input logic [31:0] gw, input logic [3:0] ifc);
		lpm_pkg::in_beat_t b;
		b.action         = lpm_pkg::ACT_ADD;
		b.lookup_address = $urandom;
		b.new_dest       = dst;
		b.new_mask       = msk;
		b.new_gateway    = gw;
		b.new_iface      = ifc;
		if (known_total < KNOWN_MAX) begin
			known_dest[known_total] = dst;
			known_mask[known_total] = msk;
			known_total++;
		end
		offer(b);
	endtask

	task automatic look_up(input logic [31:0] addr);
		lpm_pkg::in_beat_t b;
		b.action         = lpm_pkg::ACT_LOOKUP;
		b.lookup_address = addr;
		b.new_dest       = $urandom;
		b.new_mask       = $urandom;
		b.new_gateway    = $urandom;
		b.new_iface      = $urandom_range(0, 15);
		offer(b);
	endtask

	function automatic logic [31:0] pick_mask();
		int len;
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2, 3, 4, 5: len = 8 * $urandom_range(0, 4);
			default: len = $urandom_range(0, 32);
		endcase
		return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
	endfunction

	initial begin
		logic [31:0] msk;
		logic [31:0] dst;
		logic [31:0] addr;
		int          k;
		int          i;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		burst_left    = 0;
		quiet_cycles  = 0;
		results_taken = 0;
		known_total   = 0;
		foreach (net_base[j]) net_base[j] = $urandom;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		look_up(32'h0000_0000);
		look_up(32'hFFFF_FFFF);
		add_route(32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 4'd1);
		look_up(32'h0B00_0000);
		add_route(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4'd15);
		add_route(32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 4'd2);
		add_route(32'h0A01_00FF, 32'hFFFF_0000, 32'h0A01_00FE, 4'd3);
		add_route(32'h0A01_0203, 32'hFFFF_FFFF, 32'h0A01_0203, 4'd4);
		add_route(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
		add_route(32'h0B00_0C00, 32'hFF00_FF00, 32'hC0A8_0001, 4'd5);
		add_route(32'h0C00_0000, 32'h7FFF_FFFF, 32'h0C00_00FE, 4'd6);
		look_up(32'h0A01_0203);
		look_up(32'h0A01_0204);
		look_up(32'h0A02_0000);
		look_up(32'h0B99_0CAA);
		look_up(32'h0B99_0DAA);
		look_up(32'hFFFF_FFFF);
		look_up(32'h0000_0000);
		look_up(32'h8C00_0000);
		look_up(32'h1234_5678);

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if ($urandom_range(0, 99) < 14) begin
				msk = pick_mask();
				if ($urandom_range(0, 9) < 7) begin
					dst = (net_base[$urandom_range(0, 3)] & msk) | ($urandom & ~msk);
				end else begin
					dst = $urandom;
				end
				add_route(dst, msk, $urandom, $urandom_range(0, 15));
			end else begin
				k = $urandom_range(0, 9);
				if (k < 6) begin
					i    = $urandom_range(0, known_total - 1);
					addr = (known_dest[i] & known_mask[i]) | ($urandom & ~known_mask[i]);
				end else if (k < 8) begin
					addr = net_base[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(0, 31));
				end else begin
					addr = $urandom;
				end
				look_up(addr);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (answers_due != 0) @(negedge clk);
		repeat (DEPTH + 8) @(negedge clk);
		if (fail_count == 0) begin
			$display("[longest_prefix_match_route_table_core] OK");
		end else begin
			$display("[longest_prefix_match_route_table_core] ERROR");
		end
		$finish;
	end

endmodule
